>>> design/aabbfc_pkg.sv
// Shared types and constants for the bounding-box frustum cull block.
package aabbfc_pkg;

    // Default coordinate width and fixed-point fraction bits
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;

    // Box axes and configuration index width
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 2;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_VERTEX = 2'd0,
        OP_PLANE  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X = 2'd0,
        CFG_POS_Y = 2'd1,
        CFG_POS_Z = 2'd2
    } t_cfg_idx;

    // Box update command from the input stage
    typedef struct packed {
        logic widen;
        logic clear;
    } t_box_cmd;

    // Control that travels with a plane item through the product stage
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

>>> design/aabb_frustum_cull_top.sv
// Top level of the bounding-box frustum cull block.
//
// Input channel (i_valid / o_stall) carries one item: a vertex that widens
// the box, a plane to test, or a clear that empties the box. Output channel
// (o_valid / i_stall) carries one culled flag for each plane item marked as
// the last of its frustum; no other item gives a result.
// Object position registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must do so only while no item is in flight, as the
// block does not enforce it. Throughput: one item per cycle unless a stalled
// result backs up the three-stage pipe (input register, corner and product
// register, sum and output register), which a last plane's flag traverses.
// A vertex item updates the box as it leaves the input register, so a plane
// in the very next cycle already sees it.
// Reset empties the box, zeroes the positions and the sticky flag and
// flushes the pipe. While the receiver stalls, the result holds; non-last
// planes still drain, and the input stalls only once every stage is full.
module aabb_frustum_cull_top #(
    parameter int COORD_WIDTH = aabbfc_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [aabbfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]           i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_op,
    input  logic [COORD_WIDTH-1:0]           i_vert_x,
    input  logic [COORD_WIDTH-1:0]           i_vert_y,
    input  logic [COORD_WIDTH-1:0]           i_vert_z,
    input  logic [COORD_WIDTH-1:0]           i_plane_a,
    input  logic [COORD_WIDTH-1:0]           i_plane_b,
    input  logic [COORD_WIDTH-1:0]           i_plane_c,
    input  logic [COORD_WIDTH-1:0]           i_plane_d,
    input  logic                             i_last_plane,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_culled
);
    import aabbfc_pkg::*;

    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_pos;

    logic                                 r_in_valid;
    logic [1:0]                           r_op;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_vert;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_normal;
    logic [COORD_WIDTH-1:0]               r_plane_d;
    logic                                 r_last;

    logic                                 is_plane;
    logic                                 in_done;
    logic                                 in_free;
    logic                                 prod_free;
    logic                                 take;
    t_box_cmd                             box_cmd;
    t_stage_ctl                           prod_ctl;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_max;
    logic [NUM_AXES-1:0][2*COORD_WIDTH-1:0] prod;
    logic [2*COORD_WIDTH-1:0]             dterm;

    // Write the object position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_X: r_pos[0] <= i_cfg_data;
                CFG_POS_Y: r_pos[1] <= i_cfg_data;
                CFG_POS_Z: r_pos[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decide whether the input register can move on
    assign is_plane  = (r_op == OP_PLANE);
    assign prod_free = !prod_ctl.valid || take;
    assign in_done   = r_in_valid && (!is_plane || prod_free);
    assign in_free   = !r_in_valid || in_done;
    assign o_stall   = !in_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_free) begin
            r_op        <= i_op;
            r_vert[0]   <= i_vert_x;
            r_vert[1]   <= i_vert_y;
            r_vert[2]   <= i_vert_z;
            r_normal[0] <= i_plane_a;
            r_normal[1] <= i_plane_b;
            r_normal[2] <= i_plane_c;
            r_plane_d   <= i_plane_d;
            r_last      <= i_last_plane;
        end
    end

    // Update the box as a vertex or clear item leaves the input register
    always_comb begin
        box_cmd = '0;
        if (in_done) begin
            case (r_op)
                OP_VERTEX: box_cmd.widen = 1'b1;
                OP_CLEAR:  box_cmd.clear = 1'b1;
                default: ;
            endcase
        end
    end

    aabbfc_box #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (box_cmd),
        .i_vert  (r_vert),
        .o_min   (box_min),
        .o_max   (box_max)
    );

    aabbfc_prod #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (prod_free),
        .i_load    (r_in_valid && is_plane),
        .i_last    (r_last),
        .i_normal  (r_normal),
        .i_plane_d (r_plane_d),
        .i_box_min (box_min),
        .i_box_max (box_max),
        .i_pos     (r_pos),
        .o_ctl     (prod_ctl),
        .o_prod    (prod),
        .o_dterm   (dterm)
    );

    aabbfc_sum #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (prod_ctl),
        .i_prod   (prod),
        .i_dterm  (dterm),
        .i_stall  (i_stall),
        .o_take   (take),
        .o_valid  (o_valid),
        .o_culled (o_culled)
    );

endmodule

>>> design/aabbfc_box.sv
// Bounding-box extremes: widened by vertex items, emptied by clear items.
module aabbfc_box #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  aabbfc_pkg::t_box_cmd                           i_cmd,
    input  logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] i_vert,
    output logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] o_min,
    output logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] o_max
);
    import aabbfc_pkg::*;

    localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] r_max;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] n_min;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] n_max;

    // Pick the new extremes per axis
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n_min[k] = r_min[k];
            n_max[k] = r_max[k];
            if (i_cmd.clear) begin
                n_min[k] = MAXV;
                n_max[k] = MINV;
            end else if (i_cmd.widen) begin
                if ($signed(i_vert[k]) < $signed(r_min[k])) begin
                    n_min[k] = i_vert[k];
                end
                if ($signed(i_vert[k]) > $signed(r_max[k])) begin
                    n_max[k] = i_vert[k];
                end
            end
        end
    end

    // Hold the box; reset leaves it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_min[k] <= MAXV;
                r_max[k] <= MINV;
            end
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

>>> design/aabbfc_prod.sv
// Product stage: positive-vertex corner, saturating offset and plane products.
module aabbfc_prod #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_adv,
    input  logic                                           i_load,
    input  logic                                           i_last,
    input  logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] i_normal,
    input  logic [COORD_WIDTH-1:0]                         i_plane_d,
    input  logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] i_box_min,
    input  logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] i_box_max,
    input  logic [aabbfc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] i_pos,
    output aabbfc_pkg::t_stage_ctl                         o_ctl,
    output logic [aabbfc_pkg::NUM_AXES-1:0][2*COORD_WIDTH-1:0] o_prod,
    output logic [2*COORD_WIDTH-1:0]                       o_dterm
);
    import aabbfc_pkg::*;

    localparam int PW = 2 * COORD_WIDTH;
    localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] corner;
    logic [NUM_AXES-1:0][COORD_WIDTH:0]   wide_sum;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] pt;
    logic [NUM_AXES-1:0][PW-1:0]          n_prod;
    logic [PW-1:0]                        n_dterm;

    t_stage_ctl                           r_ctl;
    logic [NUM_AXES-1:0][PW-1:0]          r_prod;
    logic [PW-1:0]                        r_dterm;

    // Take max corner for a non-negative component, min otherwise; add position
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            corner[k]   = i_normal[k][COORD_WIDTH-1] ? i_box_min[k] : i_box_max[k];
            wide_sum[k] = {corner[k][COORD_WIDTH-1], corner[k]}
                        + {i_pos[k][COORD_WIDTH-1], i_pos[k]};
            if (wide_sum[k][COORD_WIDTH] != wide_sum[k][COORD_WIDTH-1]) begin
                pt[k] = wide_sum[k][COORD_WIDTH] ? MINV : MAXV;
            end else begin
                pt[k] = wide_sum[k][COORD_WIDTH-1:0];
            end
            n_prod[k] = $signed(i_normal[k]) * $signed(pt[k]);
        end
        n_dterm = {{(COORD_WIDTH-FRAC_BITS){i_plane_d[COORD_WIDTH-1]}},
                   i_plane_d, {FRAC_BITS{1'b0}}};
    end

    // Advance the stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl.valid <= i_load;
            r_ctl.last  <= i_last;
        end
    end

    // Capture the products of a plane item
    always_ff @(posedge i_clk) begin
        if (i_adv && i_load) begin
            r_prod  <= n_prod;
            r_dterm <= n_dterm;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_prod  = r_prod;
    assign o_dterm = r_dterm;

endmodule

>>> design/aabbfc_sum.sv
// Result stage: plane distance sign, sticky cull flag and output register.
module aabbfc_sum #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  aabbfc_pkg::t_stage_ctl                             i_ctl,
    input  logic [aabbfc_pkg::NUM_AXES-1:0][2*COORD_WIDTH-1:0] i_prod,
    input  logic [2*COORD_WIDTH-1:0]                           i_dterm,
    input  logic                                               i_stall,
    output logic                                               o_take,
    output logic                                               o_valid,
    output logic                                               o_culled
);
    import aabbfc_pkg::*;

    localparam int SW = 2 * COORD_WIDTH + 2;

    logic [SW-1:0] plane_dist;
    logic          behind;
    logic          out_free;
    logic          take;

    logic          r_cull_seen;
    logic          r_valid;
    logic          r_culled;

    // Sum the exact plane distance and read its sign
    always_comb begin
        plane_dist = SW'($signed(i_dterm));
        for (int k = 0; k < NUM_AXES; k++) begin
            plane_dist = plane_dist + SW'($signed(i_prod[k]));
        end
        behind = plane_dist[SW-1];
    end

    // Consume a non-last plane at once; a last plane needs the output register
    assign out_free = !r_valid || !i_stall;
    assign take     = i_ctl.valid && (!i_ctl.last || out_free);

    // Collect culling over the planes of one frustum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_seen <= 1'b0;
        end else if (take) begin
            r_cull_seen <= i_ctl.last ? 1'b0 : (r_cull_seen | behind);
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= take && i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && take && i_ctl.last) begin
            r_culled <= r_cull_seen | behind;
        end
    end

    assign o_take   = take;
    assign o_valid  = r_valid;
    assign o_culled = r_culled;

endmodule

>>> design/aabbfc_checker.sv
// Port-level checks for the frustum cull block, bound to its top level.
module aabbfc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_culled
);

    // A stalled result holds its flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_culled))
        else $error("stalled result changed");

    // Reset flushes the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // With the output register empty the pipe always drains, so the input is free
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // The input can only back up after a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stall without output stall");

endmodule

bind aabb_frustum_cull_top aabbfc_checker u_aabbfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_culled (o_culled)
);
